// File: hw/rtl/sbfr_pkg.sv
// Shared types and constants for the sensor board frame receiver.
package sbfr_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int STORE_DEPTH = FRAME_BYTES - 1;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_BYTES - 1);

    localparam logic [3:0] SYNC_NIBBLE = 4'hC;
    localparam logic [7:0] CODE_PEDAL  = 8'h55;
    localparam logic [7:0] CODE_FREE   = 8'hAA;
    localparam logic [8:0] GYRO_OFFSET = 9'h058;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_ANGLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_ENABLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COUNT = 2'd3;

    localparam logic        RST_INVERT_ANGLE  = 1'b1;
    localparam logic        RST_GYRO_ENABLE   = 1'b0;
    localparam logic [15:0] RST_TIMEOUT_LIMIT = 16'd30000;
    localparam logic [3:0]  RST_RELEASE_COUNT = 4'd8;

    typedef struct packed {
        logic        invert_angle;
        logic        gyro_enable;
        logic [15:0] timeout_limit;
        logic [3:0]  release_count;
    } cfg_t;

    // A completed frame, valid for the beat that carries its last byte
    typedef struct packed {
        logic        done;
        logic [7:0]  remote_byte;
        logic [7:0]  code;
        logic [15:0] angle_a;
        logic [15:0] angle_b;
        logic [7:0]  gyro_a;
        logic [7:0]  gyro_b;
    } frame_t;

    typedef struct packed {
        logic timeout;
        logic link_lost;
    } link_t;

    typedef struct packed {
        logic [3:0]  remote;
        logic [17:0] angle;
        logic        pedal;
        logic [8:0]  gyro;
        logic        frame_error;
    } status_t;

endpackage

// File: hw/rtl/sbfr_frame_asm.sv
// Frame assembler: byte position, header resync and byte store.
module sbfr_frame_asm
    import sbfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_en,
    input  logic [7:0] rx_byte,
    output frame_t     frame
);

    logic [IDX_W-1:0] byte_index_reg;
    logic [IDX_W-1:0] byte_index_next;
    logic [7:0]       store_reg [STORE_DEPTH];

    always_comb begin
        byte_index_next = byte_index_reg;
        if (byte_en) begin
            if (byte_index_reg == IDX_LAST) begin
                byte_index_next = '0;
            end else if (byte_index_reg == IDX_W'(0) && rx_byte[7:4] != SYNC_NIBBLE) begin
                byte_index_next = '0;
            end else if (byte_index_reg == IDX_W'(1) && rx_byte != CODE_PEDAL
                         && rx_byte != CODE_FREE) begin
                byte_index_next = '0;
            end else begin
                byte_index_next = byte_index_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= '0;
        end else begin
            byte_index_reg <= byte_index_next;
        end
    end

    // The last byte is used straight from the beat, never stored
    always_ff @(posedge aclk) begin
        if (byte_en && byte_index_reg != IDX_LAST) begin
            store_reg[byte_index_reg] <= rx_byte;
        end
    end

    always_comb begin
        frame.done        = byte_en && byte_index_reg == IDX_LAST;
        frame.remote_byte = store_reg[0];
        frame.code        = store_reg[1];
        frame.angle_a     = {store_reg[3], store_reg[2]};
        frame.angle_b     = {store_reg[5], store_reg[4]};
        frame.gyro_a      = store_reg[6];
        frame.gyro_b      = rx_byte;
    end

endmodule

// File: hw/rtl/sbfr_link_timer.sv
// Idle tick counter with link timeout and sticky link-lost flag.
module sbfr_link_timer
    import sbfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        beat_en,
    input  logic        byte_present,
    input  logic [15:0] timeout_limit,
    output link_t       link
);

    logic [15:0] idle_ticks_reg;
    logic [15:0] idle_ticks_next;
    logic        link_lost_reg;
    logic        timeout;

    always_comb begin
        timeout         = 1'b0;
        idle_ticks_next = idle_ticks_reg;
        if (beat_en) begin
            if (byte_present) begin
                idle_ticks_next = '0;
            end else if (idle_ticks_reg >= timeout_limit) begin
                // hold the count; every further tick times out again
                timeout = 1'b1;
            end else begin
                idle_ticks_next = idle_ticks_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_ticks_reg <= '0;
            link_lost_reg  <= 1'b0;
        end else begin
            idle_ticks_reg <= idle_ticks_next;
            link_lost_reg  <= link.link_lost;
        end
    end

    assign link.timeout   = timeout;
    assign link.link_lost = link_lost_reg | timeout;

endmodule

// File: hw/rtl/sbfr_frame_proc.sv
// Frame decoder: remote debounce, angle check and sum, pedal hold, gyro capture.
module sbfr_frame_proc
    import sbfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  frame_t  frame,
    input  cfg_t    cfg,
    input  logic    timeout,
    output status_t status_next
);

    status_t     status_reg;
    logic [3:0]  prev_nibble_reg;
    logic [3:0]  prev_nibble_next;
    logic [15:0] last_raw_reg;
    logic [15:0] last_raw_next;
    logic [3:0]  pedal_hold_reg;
    logic [3:0]  pedal_hold_next;
    logic [3:0]  nibble;
    logic [17:0] sum;

    assign nibble = frame.remote_byte[3:0];
    assign sum    = {{2{frame.angle_a[15]}}, frame.angle_a}
                  + {{2{last_raw_reg[15]}}, last_raw_reg};

    always_comb begin
        status_next      = status_reg;
        prev_nibble_next = prev_nibble_reg;
        last_raw_next    = last_raw_reg;
        pedal_hold_next  = pedal_hold_reg;
        if (timeout) begin
            status_next.remote = '0;
        end
        if (frame.done) begin
            if (nibble == prev_nibble_reg) begin
                status_next.remote = nibble;
            end
            prev_nibble_next = nibble;
            if (frame.angle_a == frame.angle_b) begin
                status_next.angle = cfg.invert_angle ? -sum : sum;
                last_raw_next     = frame.angle_a;
                if (frame.code == CODE_PEDAL) begin
                    status_next.pedal = 1'b1;
                    pedal_hold_next   = '0;
                end else if (pedal_hold_reg >= cfg.release_count) begin
                    status_next.pedal = 1'b0;
                end else begin
                    pedal_hold_next = pedal_hold_reg + 4'd1;
                end
                if (cfg.gyro_enable && frame.gyro_a == frame.gyro_b) begin
                    status_next.gyro = {1'b0, frame.gyro_a} - GYRO_OFFSET;
                end
            end else begin
                // mismatch: keep angle, pedal and gyro
                status_next.frame_error = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg      <= '0;
            prev_nibble_reg <= '0;
            last_raw_reg    <= '0;
            pedal_hold_reg  <= '0;
        end else begin
            status_reg      <= status_next;
            prev_nibble_reg <= prev_nibble_next;
            last_raw_reg    <= last_raw_next;
            pedal_hold_reg  <= pedal_hold_next;
        end
    end

endmodule

// File: hw/rtl/sensor_board_frame_receiver.sv
// Each accepted input beat has its result beat in the output register from the next cycle.
// One beat per cycle unless stalled; all frame and timer state updates in the accepting cycle.
// s_tready stays high while the output register is empty or being drained.
// Reset (aresetn low, synchronous) clears frame position, status, timer and output valid,
// and loads the configuration defaults; the frame byte store is not cleared.
module sensor_board_frame_receiver
    import sbfr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    input  logic                  s_tuser,   // [0] byte_present
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [3:0] remote_value, [21:4] angle_sum, [22] pedal_on, [31:23] gyro_value,
    // [32] frame_error, [33] link_lost, [34] timeout, [39:35] zero
    output logic [39:0]           m_tdata,
    output logic                  m_tlast,   // frame_done
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg_reg;
    frame_t  frame;
    link_t   link;
    status_t status_next;
    logic    accept;
    logic    m_tvalid_reg;
    logic    m_tvalid_next;
    logic [39:0] m_tdata_reg;
    logic    m_tlast_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.invert_angle  <= RST_INVERT_ANGLE;
            cfg_reg.gyro_enable   <= RST_GYRO_ENABLE;
            cfg_reg.timeout_limit <= RST_TIMEOUT_LIMIT;
            cfg_reg.release_count <= RST_RELEASE_COUNT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_INVERT_ANGLE:  cfg_reg.invert_angle  <= cfg_wdata[0];
                CFG_GYRO_ENABLE:   cfg_reg.gyro_enable   <= cfg_wdata[0];
                CFG_TIMEOUT_LIMIT: cfg_reg.timeout_limit <= cfg_wdata[15:0];
                CFG_RELEASE_COUNT: cfg_reg.release_count <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    sbfr_frame_asm u_frame_asm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (accept && s_tuser),
        .rx_byte (s_tdata),
        .frame   (frame)
    );

    sbfr_link_timer u_link_timer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .beat_en       (accept),
        .byte_present  (s_tuser),
        .timeout_limit (cfg_reg.timeout_limit),
        .link          (link)
    );

    sbfr_frame_proc u_frame_proc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame       (frame),
        .cfg         (cfg_reg),
        .timeout     (link.timeout),
        .status_next (status_next)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // load the result beat; hold it while stalled
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {5'd0, link.timeout, link.link_lost, status_next.frame_error,
                            status_next.gyro, status_next.pedal, status_next.angle,
                            status_next.remote};
            m_tlast_reg <= frame.done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
